>>> hw/rtl/bldq_pkg.sv
// Shared types and constants for the bounded list deque sorter.
// Holds request/response payloads, op and status codes, FSM states and
// the command/status structs between controller and datapath.
package bldq_pkg;

  localparam int DEPTH_DEF   = 32;
  localparam int MAX_RESULTS = 32;

  typedef enum logic [3:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_SORT_INS   = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_POP_BACK   = 4'd4,
    OP_READ       = 4'd5,
    OP_SORT       = 4'd6,
    OP_DUMP       = 4'd7,
    OP_DUMP_REV   = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] value;
    logic [5:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [5:0]         count;
    logic               last;
  } rsp_t;

  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_SORT,
    KIND_DUMP
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SORT_INIT,
    S_SORT_KEY,
    S_SORT_KEYW,
    S_SORT_CMP,
    S_SORT_PLACE,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load_req;
    logic decode;
    logic sort_init;
    logic key_rd;
    logic key_load;
    logic cmp_step;
    logic place;
    logic dump_rd;
    logic emit;
    logic emit_dump;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  sort_short;
    logic  shift;
    logic  j_one;
    logic  i_done;
    logic  dump_last;
  } sts_t;

endpackage

>>> hw/rtl/bounded_list_deque_sorter.sv
// Bounded deque of signed 32-bit values with push/pop at both ends, sorted
// insert, positional read, in-place insertion sort and forward/reverse dumps.
// Top level; depends on bldq_pkg, bldq_ctrl and bldq_dp.
//
// One request is worked at a time; the next is taken as soon as the previous
// one's last response sits in the output register. Pushes, pops, reads, error
// cases and unused codes pass through a decode state and a response state. A
// dump does one memory read and one response per entry, at most 32 responses.
// Sort and sorted insert walk the entries with one read and one write port on
// the entry memory: per entry a key read, a key load, compare steps that move
// larger entries up by one slot, and a place write. The entry memory starts
// undefined and needs no clearing pass after reset.
module bounded_list_deque_sorter #(
  parameter int DEPTH = bldq_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bldq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bldq_pkg::rsp_t rsp
);

  bldq_pkg::cmd_t cmd;
  bldq_pkg::sts_t sts;

  bldq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bldq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

>>> hw/rtl/bldq_dp.sv
// Datapath of the deque sorter: entry ring memory, front/fill pointers,
// sort and dump counters, request latch and response register.
// Depends on bldq_pkg; driven by commands from bldq_ctrl.
module bldq_dp #(
  parameter int DEPTH = bldq_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  bldq_pkg::req_t  req,
  input  bldq_pkg::cmd_t  cmd,
  output bldq_pkg::sts_t  sts,
  output bldq_pkg::rsp_t  rsp
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CmpW = (CW > 6) ? CW : 6;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] f, input logic [IW-1:0] k);
    logic [IW:0] s;
    s = {1'b0, f} + {1'b0, k};
    if (s >= (IW+1)'(DEPTH)) begin
      return IW'(s - (IW+1)'(DEPTH));
    end
    return IW'(s);
  endfunction

  bldq_pkg::req_t      cur;
  logic [IW-1:0]       front;
  logic [CW-1:0]       fill;
  logic [CW-1:0]       idx;
  logic [IW-1:0]       j;
  logic signed [31:0]  key;
  bldq_pkg::status_t   res_status;
  logic                res_mem;

  logic signed [31:0]  mem [DEPTH];
  logic signed [31:0]  rd_data;

  logic                full;
  logic                empty;
  logic                bad_pos;
  bldq_pkg::status_t   dec_status;
  logic                dec_mem;
  logic                dec_push;
  bldq_pkg::kind_t     kind;
  logic [IW-1:0]       front_dec;
  logic [IW-1:0]       front_inc;
  logic                rd_en;
  logic [IW-1:0]       rd_off;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic signed [31:0]  wr_data;
  logic                shift;
  logic                j_one;
  logic [CW-1:0]       idx_inc;
  logic                dump_last;

  assign full      = (fill == CW'(DEPTH));
  assign empty     = (fill == '0);
  assign bad_pos   = (cur.position == 6'd0) || (CmpW'(cur.position) > CmpW'(fill));
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
  assign shift     = key < rd_data;
  assign j_one     = (j == IW'(1));
  assign idx_inc   = idx + CW'(1);
  assign dump_last = (idx_inc == fill) ||
                     (CmpW'(idx_inc) == CmpW'(bldq_pkg::MAX_RESULTS));

  always_comb begin
    dec_status = bldq_pkg::ST_OK;
    dec_mem    = 1'b0;
    dec_push   = 1'b0;
    kind       = bldq_pkg::KIND_SINGLE;
    unique case (cur.op) inside
      bldq_pkg::OP_PUSH_FRONT, bldq_pkg::OP_PUSH_BACK, bldq_pkg::OP_SORT_INS: begin
        if (full) begin
          dec_status = bldq_pkg::ST_FULL;
        end else begin
          dec_push = 1'b1;
          if (cur.op == bldq_pkg::OP_SORT_INS) kind = bldq_pkg::KIND_SORT;
        end
      end
      bldq_pkg::OP_POP_FRONT, bldq_pkg::OP_POP_BACK: begin
        if (empty) dec_status = bldq_pkg::ST_EMPTY;
        else dec_mem = 1'b1;
      end
      bldq_pkg::OP_READ: begin
        if (empty) dec_status = bldq_pkg::ST_EMPTY;
        else if (bad_pos) dec_status = bldq_pkg::ST_BADPOS;
        else dec_mem = 1'b1;
      end
      bldq_pkg::OP_SORT: begin
        if (empty) dec_status = bldq_pkg::ST_EMPTY;
        else kind = bldq_pkg::KIND_SORT;
      end
      bldq_pkg::OP_DUMP, bldq_pkg::OP_DUMP_REV: begin
        if (empty) dec_status = bldq_pkg::ST_EMPTY;
        else kind = bldq_pkg::KIND_DUMP;
      end
      default: begin
        dec_status = bldq_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    rd_en  = 1'b0;
    rd_off = '0;
    if (cmd.decode) begin
      rd_en = dec_mem;
      if (cur.op == bldq_pkg::OP_POP_BACK) rd_off = IW'(fill - CW'(1));
      else if (cur.op == bldq_pkg::OP_READ) rd_off = IW'(cur.position - 6'd1);
    end else if (cmd.key_rd) begin
      rd_en  = 1'b1;
      rd_off = IW'(idx);
    end else if (cmd.key_load) begin
      rd_en  = 1'b1;
      rd_off = j - IW'(1);
    end else if (cmd.cmp_step) begin
      rd_en  = shift && !j_one;
      rd_off = j - IW'(1) - IW'(1);
    end else if (cmd.dump_rd) begin
      rd_en  = 1'b1;
      rd_off = (cur.op == bldq_pkg::OP_DUMP) ? IW'(idx) : IW'(fill - CW'(1) - idx);
    end
    rd_addr = slot(front, rd_off);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot(front, j);
    wr_data = cur.value;
    if (cmd.decode) begin
      wr_en   = dec_push;
      wr_addr = (cur.op == bldq_pkg::OP_PUSH_BACK) ? slot(front, IW'(fill)) : front_dec;
    end else if (cmd.cmp_step) begin
      wr_en   = shift;
      wr_data = rd_data;
    end else if (cmd.place) begin
      wr_en   = 1'b1;
      wr_data = key;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      fill  <= '0;
    end else if (cmd.decode) begin
      if (dec_push) begin
        fill <= fill + CW'(1);
        if (cur.op != bldq_pkg::OP_PUSH_BACK) front <= front_dec;
      end else if (dec_mem && cur.op != bldq_pkg::OP_READ) begin
        fill <= fill - CW'(1);
        if (cur.op == bldq_pkg::OP_POP_FRONT) front <= front_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) cur <= req;
    if (cmd.decode) begin
      res_status <= dec_status;
      res_mem    <= dec_mem;
      idx        <= '0;
    end
    if (cmd.sort_init) idx <= CW'(1);
    if (cmd.key_rd) j <= IW'(idx);
    if (cmd.key_load) key <= rd_data;
    if (cmd.cmp_step && shift) j <= j - IW'(1);
    if (cmd.place || cmd.emit_dump) idx <= idx_inc;
    if (cmd.emit) begin
      rsp.status <= res_status;
      rsp.data   <= res_mem ? rd_data : '0;
      rsp.count  <= 6'(fill);
      rsp.last   <= 1'b1;
    end else if (cmd.emit_dump) begin
      rsp.status <= bldq_pkg::ST_OK;
      rsp.data   <= rd_data;
      rsp.count  <= 6'(fill);
      rsp.last   <= dump_last;
    end
  end

  assign sts.kind       = kind;
  assign sts.sort_short = (fill < CW'(2));
  assign sts.shift      = shift;
  assign sts.j_one      = j_one;
  assign sts.i_done     = (idx_inc == fill);
  assign sts.dump_last  = dump_last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count above depth");

  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write hit the same entry");

  a_cmp_j: assert property (@(posedge clk) disable iff (rst)
    cmd.cmp_step |-> (j != '0))
    else $error("sort compare with no predecessor");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    cmd.key_rd |-> (idx < fill))
    else $error("sort key beyond fill");

  a_pop_front: assert property (@(posedge clk) disable iff (rst)
    (cmd.decode && dec_mem && cur.op == bldq_pkg::OP_POP_FRONT) |=>
      (fill == $past(fill) - CW'(1)) && (front == $past(front_inc)))
    else $error("pop front did not advance");

endmodule

>>> hw/rtl/bldq_ctrl.sv
// Controller FSM of the deque sorter: request/response handshakes and
// sequencing of decode, insertion sort and dump walks.
// Depends on bldq_pkg; commands bldq_dp and reads its status.
module bldq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  bldq_pkg::sts_t sts,
  output bldq_pkg::cmd_t cmd
);

  bldq_pkg::state_t state;
  bldq_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bldq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_dump) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      bldq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = bldq_pkg::S_DECODE;
        end
      end
      bldq_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        unique case (sts.kind)
          bldq_pkg::KIND_SORT: state_next = bldq_pkg::S_SORT_INIT;
          bldq_pkg::KIND_DUMP: state_next = bldq_pkg::S_DUMP_RD;
          default:             state_next = bldq_pkg::S_RESP;
        endcase
      end
      bldq_pkg::S_SORT_INIT: begin
        cmd.sort_init = 1'b1;
        state_next    = sts.sort_short ? bldq_pkg::S_RESP : bldq_pkg::S_SORT_KEY;
      end
      bldq_pkg::S_SORT_KEY: begin
        cmd.key_rd = 1'b1;
        state_next = bldq_pkg::S_SORT_KEYW;
      end
      bldq_pkg::S_SORT_KEYW: begin
        cmd.key_load = 1'b1;
        state_next   = bldq_pkg::S_SORT_CMP;
      end
      bldq_pkg::S_SORT_CMP: begin
        cmd.cmp_step = 1'b1;
        if (!sts.shift || sts.j_one) state_next = bldq_pkg::S_SORT_PLACE;
      end
      bldq_pkg::S_SORT_PLACE: begin
        cmd.place  = 1'b1;
        state_next = sts.i_done ? bldq_pkg::S_RESP : bldq_pkg::S_SORT_KEY;
      end
      bldq_pkg::S_DUMP_RD: begin
        cmd.dump_rd = 1'b1;
        state_next  = bldq_pkg::S_DUMP_OUT;
      end
      bldq_pkg::S_DUMP_OUT: begin
        if (out_free) begin
          cmd.emit_dump = 1'b1;
          state_next    = sts.dump_last ? bldq_pkg::S_IDLE : bldq_pkg::S_DUMP_RD;
        end
      end
      bldq_pkg::S_RESP: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = bldq_pkg::S_IDLE;
        end
      end
    endcase
  end

endmodule

>>> sim/bounded_list_deque_sorter_tb.sv
// Self-checking testbench for bounded_list_deque_sorter: drives deque requests over
// valid/ready and checks every response against a cycle-free deque predictor.
// Depends on bldq_pkg and the bounded_list_deque_sorter RTL.
module bounded_list_deque_sorter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bldq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [3:0] OP_SPARE_FIRST = 4'd9;
  localparam logic [3:0] OP_SPARE_LAST = 4'd15;
  localparam int PHASE_REQS = 64;
  localparam int TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  req_t req_pending_q[$];
  rsp_t rsp_due_q[$];

  logic signed [31:0] held_vals[DEPTH];
  int head_slot = 0;
  int held = 0;
  int peak_held = 0;

  int gen_held = 0;
  int phase_reqs = 0;
  int send_idle_pct = 25;
  int recv_idle_pct = 48;
  int mismatches = 0;
  int reqs_accepted = 0;
  int rsps_checked = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  bounded_list_deque_sorter #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void queue_due(status_t st, logic signed [31:0] d, logic lst);
    rsp_t x;
    x.status = st;
    x.data = d;
    x.count = 6'(held);
    x.last = lst;
    rsp_due_q.push_back(x);
  endfunction

  function automatic void sort_held();
    logic signed [31:0] walk[DEPTH];
    logic signed [31:0] key;
    int i;
    int j;
    for (i = 0; i < held; i++) walk[i] = held_vals[(head_slot + i) % DEPTH];
    for (i = 1; i < held; i++) begin
      key = walk[i];
      j = i;
      while (j > 0 && key < walk[j-1]) begin
        walk[j] = walk[j-1];
        j--;
      end
      walk[j] = key;
    end
    for (i = 0; i < held; i++) held_vals[(head_slot + i) % DEPTH] = walk[i];
  endfunction

  function automatic void apply_deque_op(req_t r);
    logic signed [31:0] d;
    int n;
    int i;
    int k;
    case (r.op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORT_INS: begin
        if (held >= DEPTH) begin
          queue_due(ST_FULL, '0, 1'b1);
        end else begin
          if (r.op == OP_PUSH_BACK) begin
            held_vals[(head_slot + held) % DEPTH] = r.value;
            held++;
          end else begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            held_vals[head_slot] = r.value;
            held++;
            if (r.op == OP_SORT_INS) sort_held();
          end
          queue_due(ST_OK, '0, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (held == 0) begin
          queue_due(ST_EMPTY, '0, 1'b1);
        end else begin
          if (r.op == OP_POP_FRONT) begin
            d = held_vals[head_slot];
            head_slot = (head_slot + 1) % DEPTH;
          end else begin
            d = held_vals[(head_slot + held - 1) % DEPTH];
          end
          held--;
          queue_due(ST_OK, d, 1'b1);
        end
      end
      OP_READ: begin
        if (held == 0) queue_due(ST_EMPTY, '0, 1'b1);
        else if (r.position == 0 || r.position > held) queue_due(ST_BADPOS, '0, 1'b1);
        else queue_due(ST_OK, held_vals[(head_slot + r.position - 1) % DEPTH], 1'b1);
      end
      OP_SORT: begin
        if (held == 0) begin
          queue_due(ST_EMPTY, '0, 1'b1);
        end else begin
          sort_held();
          queue_due(ST_OK, '0, 1'b1);
        end
      end
      OP_DUMP, OP_DUMP_REV: begin
        if (held == 0) begin
          queue_due(ST_EMPTY, '0, 1'b1);
        end else begin
          n = (held < MAX_RESULTS) ? held : MAX_RESULTS;
          for (i = 0; i < n; i++) begin
            k = (r.op == OP_DUMP) ? i : held - 1 - i;
            queue_due(ST_OK, held_vals[(head_slot + k) % DEPTH], i == n - 1);
          end
        end
      end
      default: queue_due(ST_OK, '0, 1'b1);
    endcase
    if (held > peak_held) peak_held = held;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        apply_deque_op(req);
        reqs_accepted++;
      end
      if (!req_valid || req_ready) begin
        if (req_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req <= req_pending_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rsp_monitor
    rsp_t due;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsps_checked++;
        status_seen[rsp.status]++;
        if (rsp_due_q.size() == 0) begin
          report_mismatch($sformatf("response %p with nothing due", rsp));
        end else begin
          due = rsp_due_q.pop_front();
          if (rsp.status !== due.status)
            report_mismatch($sformatf("status %0d, want %0d", rsp.status, due.status));
          if (rsp.data !== due.data)
            report_mismatch($sformatf("data %0d, want %0d", rsp.data, due.data));
          if (rsp.count !== due.count)
            report_mismatch($sformatf("count %0d, want %0d", rsp.count, due.count));
          if (rsp.last !== due.last)
            report_mismatch($sformatf("last %0b, want %0b", rsp.last, due.last));
        end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic add_req(logic [3:0] op, logic signed [31:0] value, logic [5:0] position);
    req_t r;
    r.op = op;
    r.value = value;
    r.position = position;
    req_pending_q.push_back(r);
    phase_reqs++;
    if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK || op == OP_SORT_INS) && gen_held < DEPTH)
      gen_held++;
    else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && gen_held > 0)
      gen_held--;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] rand_pos();
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [3:0] rand_push();
    return 4'($urandom_range(OP_PUSH_FRONT, OP_SORT_INS));
  endfunction

  function automatic logic [3:0] rand_pop();
    return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  task automatic fill_to_full();
    while (gen_held < DEPTH) add_req(rand_push(), rand_value(), rand_pos());
    repeat ($urandom_range(1, 2)) add_req(rand_push(), rand_value(), rand_pos());
  endtask

  task automatic build_phase();
    phase_reqs = 0;
    fill_to_full();
    add_req(OP_DUMP, rand_value(), rand_pos());
    add_req(OP_DUMP_REV, rand_value(), rand_pos());
    while (phase_reqs < PHASE_REQS) begin
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(2, 10)) add_req(rand_push(), rand_value(), rand_pos());
        2: begin
          while (gen_held > 0) add_req(rand_pop(), rand_value(), rand_pos());
          add_req(rand_pop(), rand_value(), rand_pos());
        end
        3: repeat ($urandom_range(1, 4)) add_req(rand_pop(), rand_value(), rand_pos());
        4, 5: repeat ($urandom_range(1, 5)) begin
          if (gen_held > 0 && $urandom_range(0, 4) != 0)
            add_req(OP_READ, rand_value(), 6'($urandom_range(1, gen_held)));
          else
            add_req(OP_READ, rand_value(), rand_pos());
        end
        6: begin
          add_req(OP_SORT, rand_value(), rand_pos());
          add_req($urandom_range(0, 1) ? OP_DUMP : OP_DUMP_REV, rand_value(), rand_pos());
        end
        7: add_req($urandom_range(0, 1) ? OP_DUMP : OP_DUMP_REV, rand_value(), rand_pos());
        8: if ($urandom_range(0, 1)) fill_to_full();
        default: add_req(4'($urandom_range(0, 15)), $urandom, rand_pos());
      endcase
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (req_pending_q.size() != 0 || req_valid || rsp_due_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int send_pct[3];
    int recv_pct[3];
    int p;
    send_pct = '{25, 48, 0};
    recv_pct = '{48, 25, 0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_req(OP_POP_FRONT, 32'sd0, 6'd0);
    add_req(OP_POP_BACK, 32'sd0, 6'd0);
    add_req(OP_READ, 32'sd0, 6'd1);
    add_req(OP_SORT, 32'sd0, 6'd0);
    add_req(OP_DUMP, 32'sd0, 6'd0);
    add_req(OP_DUMP_REV, 32'sd0, 6'd0);
    add_req(OP_SPARE_FIRST, $urandom, 6'd63);
    add_req(OP_SPARE_LAST, $urandom, 6'd0);
    add_req(OP_PUSH_FRONT, 32'sh8000_0000, 6'd0);
    add_req(OP_PUSH_BACK, 32'sh7fff_ffff, 6'd63);
    add_req(OP_SORT_INS, -32'sd1, 6'd0);
    add_req(OP_PUSH_FRONT, 32'sd0, 6'd0);
    add_req(OP_SORT_INS, 32'sh7fff_ffff, 6'd0);
    add_req(OP_READ, 32'sd0, 6'd0);
    add_req(OP_READ, 32'sd0, 6'd6);
    add_req(OP_READ, 32'sd0, 6'd63);
    add_req(OP_READ, 32'sd0, 6'd5);
    add_req(OP_PUSH_BACK, 32'sh0000_5a5a, 6'd0);
    add_req(OP_SORT, 32'sd0, 6'd0);
    add_req(OP_DUMP, 32'sd0, 6'd0);
    add_req(OP_DUMP_REV, 32'sd0, 6'd0);
    add_req(OP_READ, 32'sd0, 6'd1);
    add_req(OP_POP_FRONT, 32'sd0, 6'd0);
    add_req(OP_POP_BACK, 32'sd0, 6'd0);
    wait_drained();

    for (p = 0; p < 3; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      build_phase();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (rsp_due_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", rsp_due_q.size()));
    $display("Covered %0d requests, %0d responses; deque held up to %0d entries.",
             reqs_accepted, rsps_checked, peak_held);
    $display("Statuses seen: ok %0d, empty %0d, full %0d, bad position %0d.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_BADPOS]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Timeout with %0d responses still due", rsp_due_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
